// File: rtl/core/gss_pkg.sv
// Shared types, constants and codes for the golden-section search sequencer.
// Used by the channel interfaces, the step logic and the top level.
package gss_pkg;

  localparam int unsigned BW_W      = 48;
  localparam int unsigned CRIT_W    = 48;
  localparam int unsigned ITER_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned GOLD_W    = 32;

  localparam int unsigned MAX_ITERATIONS_DEF = 100;
  localparam int unsigned FRACTION_BITS_DEF  = 16;

  // (sqrt(5)-1)/2 in Q0.32
  localparam logic [GOLD_W-1:0] GOLDEN_Q32 = 32'd2654435769;

  typedef logic [BW_W-1:0]          bw_t;
  typedef logic signed [CRIT_W-1:0] crit_t;

  localparam bw_t   BW_MAX   = {BW_W{1'b1}};
  localparam crit_t CRIT_MAX = {1'b0, {(CRIT_W-1){1'b1}}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_UPPER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_MODE = 2'd2;

  // item function codes
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_DELIVER = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND,
    PH_ITER
  } phase_e;

  typedef struct packed {
    logic  func;
    crit_t criterion;
    logic  criterion_failed;
  } gss_item_t;

  typedef struct packed {
    logic              probe_valid;
    bw_t               probe_bandwidth;
    logic              done_res;
    bw_t               best_bandwidth;
    logic              record_valid;
    bw_t               record_bandwidth;
    crit_t             record_criterion;
    logic [ITER_W-1:0] iterations;
  } gss_result_t;

  typedef struct packed {
    bw_t               step_length;
    bw_t               upper_probe;
    bw_t               lower_probe;
    crit_t             upper_value;
    crit_t             lower_value;
    logic [ITER_W-1:0] iteration_count;
    phase_e            phase;
    logic              pending_is_upper;
  } gss_state_t;

endpackage

// File: rtl/core/gss_item_if.sv
// Input item channel of the golden-section search sequencer.
// Depends on gss_pkg for field widths.
interface gss_item_if;
  logic              valid;
  logic              ready;
  logic              func;
  gss_pkg::crit_t    criterion;
  logic              criterion_failed;

  modport source (output valid, func, criterion, criterion_failed, input ready);
  modport sink   (input valid, func, criterion, criterion_failed, output ready);
endinterface

// File: rtl/core/gss_result_if.sv
// Result item channel of the golden-section search sequencer.
// Depends on gss_pkg for field widths.
interface gss_result_if;
  logic                       valid;
  logic                       ready;
  logic                       probe_valid;
  gss_pkg::bw_t               probe_bandwidth;
  logic                       done_res;
  gss_pkg::bw_t               best_bandwidth;
  logic                       record_valid;
  gss_pkg::bw_t               record_bandwidth;
  gss_pkg::crit_t             record_criterion;
  logic [gss_pkg::ITER_W-1:0] iterations;

  modport source (
    output valid, probe_valid, probe_bandwidth, done_res, best_bandwidth,
           record_valid, record_bandwidth, record_criterion, iterations,
    input  ready
  );
  modport sink (
    input  valid, probe_valid, probe_bandwidth, done_res, best_bandwidth,
           record_valid, record_bandwidth, record_criterion, iterations,
    output ready
  );
endinterface

// File: rtl/core/gss_cfg_if.sv
// Configuration write channel of the golden-section search sequencer.
// Depends on gss_pkg for index and data widths.
interface gss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gss_pkg::CFG_IDX_W-1:0] index;
  gss_pkg::bw_t                  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/golden_section_search_sequencer.sv
// Golden-section search sequencer, top level.
// Path: a result item leaves through the input register, then the step logic
// into the result register.
// Throughput: one item per cycle while results are taken; the golden-ratio
// multiply and the compares of the step logic fit between the two registers.
// Reset: search state, phase, configuration and valid flags clear at once; no clearing pass.
module golden_section_search_sequencer #(
  parameter int unsigned MAX_ITERATIONS = gss_pkg::MAX_ITERATIONS_DEF,
  parameter int unsigned FRACTION_BITS  = gss_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gss_item_if.sink          item_i,
  gss_result_if.source      result_o,
  gss_cfg_if.sink           cfg_i
);

  gss_pkg::bw_t         search_lower_q;
  gss_pkg::bw_t         search_upper_q;
  logic                 integer_mode_q;

  logic                 item_valid_q;
  gss_pkg::gss_item_t   item_q;
  logic                 out_valid_q;
  gss_pkg::gss_result_t out_q;

  gss_pkg::gss_state_t  state_q;
  gss_pkg::gss_state_t  state_d;
  gss_pkg::gss_result_t result_d;

  logic                 advance;
  logic                 fire;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_lower_q <= '0;
      search_upper_q <= '0;
      integer_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        gss_pkg::CFG_SEARCH_LOWER: search_lower_q <= cfg_i.data;
        gss_pkg::CFG_SEARCH_UPPER: search_upper_q <= cfg_i.data;
        gss_pkg::CFG_INTEGER_MODE: integer_mode_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // step the held item when the result register is free or being drained
  assign advance      = !out_valid_q || result_o.ready;
  assign fire         = item_valid_q && advance;
  assign item_i.ready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (item_i.ready) begin
        item_valid_q <= item_i.valid;
      end
      if (advance) begin
        out_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      item_q.func             <= item_i.func;
      item_q.criterion        <= item_i.criterion;
      item_q.criterion_failed <= item_i.criterion_failed;
    end
    if (fire) begin
      out_q <= result_d;
    end
  end

  gss_step #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_step (
    .state_i        (state_q),
    .item_i         (item_q),
    .search_lower_i (search_lower_q),
    .search_upper_i (search_upper_q),
    .integer_mode_i (integer_mode_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.step_length      <= '0;
      state_q.upper_probe      <= '0;
      state_q.lower_probe      <= '0;
      state_q.upper_value      <= gss_pkg::CRIT_MAX;
      state_q.lower_value      <= gss_pkg::CRIT_MAX;
      state_q.iteration_count  <= '0;
      state_q.phase            <= gss_pkg::PH_IDLE;
      state_q.pending_is_upper <= 1'b1;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.probe_valid      = out_q.probe_valid;
  assign result_o.probe_bandwidth  = out_q.probe_bandwidth;
  assign result_o.done_res         = out_q.done_res;
  assign result_o.best_bandwidth   = out_q.best_bandwidth;
  assign result_o.record_valid     = out_q.record_valid;
  assign result_o.record_bandwidth = out_q.record_bandwidth;
  assign result_o.record_criterion = out_q.record_criterion;
  assign result_o.iterations       = out_q.iterations;

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.iteration_count <= gss_pkg::ITER_W'(MAX_ITERATIONS))
    else $error("iteration count past limit");

  a_probe_or_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.probe_valid && out_q.done_res))
    else $error("result both probes and finishes");

  a_record_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_q.func == gss_pkg::FUNC_DELIVER && !item_q.criterion_failed
     && state_q.phase != gss_pkg::PH_IDLE) |=> (out_valid_q && out_q.record_valid))
    else $error("good criterion not echoed for recording");

  a_start_probes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_q.func == gss_pkg::FUNC_START)
      |=> (state_q.phase == gss_pkg::PH_FIRST && out_q.probe_valid))
    else $error("start did not issue first probe");

endmodule

// File: rtl/core/gss_scale.sv
// Golden-ratio step scaler: y = floor(x * GOLDEN_Q32 / 2^32).
// Two half-width partial products; depends on gss_pkg.
module gss_scale (
  input  gss_pkg::bw_t x_i,
  output gss_pkg::bw_t y_o
);

  localparam int unsigned SPLIT  = gss_pkg::BW_W / 2;
  localparam int unsigned PROD_W = SPLIT + gss_pkg::GOLD_W;

  logic [SPLIT-1:0]          part_hi;
  logic [SPLIT-1:0]          part_lo;
  logic [PROD_W-1:0]         prod_hi;
  logic [PROD_W-1:0]         prod_lo;
  logic [PROD_W:0]           low_sum;
  logic [gss_pkg::BW_W:0]    total;

  assign part_hi = x_i[gss_pkg::BW_W-1:SPLIT];
  assign part_lo = x_i[SPLIT-1:0];
  assign prod_hi = PROD_W'(part_hi) * PROD_W'(gss_pkg::GOLDEN_Q32);
  assign prod_lo = PROD_W'(part_lo) * PROD_W'(gss_pkg::GOLDEN_Q32);

  // low partial product plus the bits of the high one that fall below 2^32
  assign low_sum = (PROD_W+1)'({prod_hi[7:0], {SPLIT{1'b0}}}) + (PROD_W+1)'(prod_lo);
  assign total   = (gss_pkg::BW_W+1)'(prod_hi[PROD_W-1:8])
                 + (gss_pkg::BW_W+1)'(low_sum[PROD_W:gss_pkg::GOLD_W]);
  assign y_o     = total[gss_pkg::BW_W-1:0];

endmodule

// File: rtl/core/gss_step.sv
// Step logic of the search: next state and result item for one input item.
// Uses gss_scale for the golden-ratio step and gss_pkg types.
module gss_step #(
  parameter int unsigned MAX_ITERATIONS = gss_pkg::MAX_ITERATIONS_DEF,
  parameter int unsigned FRACTION_BITS  = gss_pkg::FRACTION_BITS_DEF
) (
  input  gss_pkg::gss_state_t  state_i,
  input  gss_pkg::gss_item_t   item_i,
  input  gss_pkg::bw_t         search_lower_i,
  input  gss_pkg::bw_t         search_upper_i,
  input  logic                 integer_mode_i,
  output gss_pkg::gss_state_t  state_o,
  output gss_pkg::gss_result_t result_o
);

  localparam int unsigned  EPS_INT   = ((1 << FRACTION_BITS) + 5000) / 10000;
  localparam gss_pkg::bw_t EPS       = gss_pkg::BW_W'(EPS_INT);
  localparam gss_pkg::bw_t FRAC_MASK = gss_pkg::BW_W'((64'd1 << FRACTION_BITS) - 64'd1);
  localparam gss_pkg::bw_t HALF      = gss_pkg::BW_W'(64'd1 << (FRACTION_BITS - 1));
  localparam logic [gss_pkg::ITER_W-1:0] ITER_LIMIT = gss_pkg::ITER_W'(MAX_ITERATIONS);

  function automatic gss_pkg::bw_t shape_floor(gss_pkg::bw_t x, logic int_mode);
    return int_mode ? (x & ~FRAC_MASK) : x;
  endfunction

  function automatic gss_pkg::bw_t shape_round(gss_pkg::bw_t x, logic int_mode);
    logic [gss_pkg::BW_W:0] s;
    gss_pkg::bw_t           r;
    s = {1'b0, x} + {1'b0, HALF};
    r = s[gss_pkg::BW_W] ? gss_pkg::BW_MAX : s[gss_pkg::BW_W-1:0];
    return int_mode ? (r & ~FRAC_MASK) : x;
  endfunction

  gss_pkg::bw_t   span_lo;
  gss_pkg::bw_t   span_hi;
  gss_pkg::bw_t   scale_in;
  gss_pkg::bw_t   scaled;
  gss_pkg::crit_t value;
  gss_pkg::crit_t upper_value_new;
  gss_pkg::crit_t lower_value_new;
  logic signed [gss_pkg::CRIT_W:0] value_diff;
  logic [gss_pkg::CRIT_W:0]        value_mag;
  logic [gss_pkg::ITER_W-1:0]      iter_new;
  logic                            keep_going;
  logic [gss_pkg::BW_W:0]          up_sum;
  gss_pkg::bw_t                    up_sat;
  gss_pkg::bw_t                    down_clamp;
  gss_pkg::gss_state_t             nxt;
  gss_pkg::gss_result_t            res;

  gss_scale u_scale (
    .x_i (scale_in),
    .y_o (scaled)
  );

  always_comb begin
    // swapped ends are put in order
    if (search_lower_i > search_upper_i) begin
      span_lo = search_upper_i;
      span_hi = search_lower_i;
    end else begin
      span_lo = search_lower_i;
      span_hi = search_upper_i;
    end
    scale_in = (item_i.func == gss_pkg::FUNC_START) ? (span_hi - span_lo)
                                                   : state_i.step_length;

    value           = item_i.criterion_failed ? gss_pkg::CRIT_MAX : item_i.criterion;
    upper_value_new = state_i.pending_is_upper ? value : state_i.upper_value;
    lower_value_new = state_i.pending_is_upper ? state_i.lower_value : value;
    iter_new        = state_i.iteration_count
                    + gss_pkg::ITER_W'(state_i.phase == gss_pkg::PH_ITER);

    value_diff = (gss_pkg::CRIT_W+1)'(lower_value_new) - (gss_pkg::CRIT_W+1)'(upper_value_new);
    value_mag  = value_diff[gss_pkg::CRIT_W] ? -value_diff : value_diff;
    keep_going = (state_i.step_length > EPS) && (value_mag > {1'b0, EPS})
              && (iter_new < ITER_LIMIT);

    up_sum     = {1'b0, state_i.lower_probe} + {1'b0, scaled};
    up_sat     = up_sum[gss_pkg::BW_W] ? gss_pkg::BW_MAX : up_sum[gss_pkg::BW_W-1:0];
    down_clamp = (state_i.upper_probe > scaled) ? (state_i.upper_probe - scaled) : '0;

    nxt = state_i;
    res = '0;

    if (item_i.func == gss_pkg::FUNC_START) begin
      nxt.step_length      = scaled;
      nxt.upper_probe      = shape_floor(span_lo + scaled, integer_mode_i);
      nxt.lower_probe      = shape_round(span_hi - scaled, integer_mode_i);
      nxt.upper_value      = gss_pkg::CRIT_MAX;
      nxt.lower_value      = gss_pkg::CRIT_MAX;
      nxt.iteration_count  = '0;
      nxt.pending_is_upper = 1'b1;
      nxt.phase            = gss_pkg::PH_FIRST;
      res.probe_valid      = 1'b1;
      res.probe_bandwidth  = nxt.upper_probe;
    end else if (state_i.phase != gss_pkg::PH_IDLE) begin
      nxt.upper_value = upper_value_new;
      nxt.lower_value = lower_value_new;
      if (!item_i.criterion_failed) begin
        res.record_valid     = 1'b1;
        res.record_criterion = item_i.criterion;
        res.record_bandwidth = state_i.pending_is_upper ? state_i.upper_probe
                                                        : state_i.lower_probe;
      end
      if (state_i.phase == gss_pkg::PH_FIRST) begin
        nxt.pending_is_upper = 1'b0;
        nxt.phase            = gss_pkg::PH_SECOND;
        res.probe_valid      = 1'b1;
        res.probe_bandwidth  = state_i.lower_probe;
      end else begin
        nxt.iteration_count = iter_new;
        if (keep_going) begin
          nxt.step_length = scaled;
          nxt.phase       = gss_pkg::PH_ITER;
          res.probe_valid = 1'b1;
          if (upper_value_new < lower_value_new) begin
            // keep the upper side: old upper probe becomes the lower one
            nxt.lower_probe      = state_i.upper_probe;
            nxt.upper_probe      = shape_round(up_sat, integer_mode_i);
            nxt.lower_value      = upper_value_new;
            nxt.pending_is_upper = 1'b1;
            res.probe_bandwidth  = nxt.upper_probe;
          end else begin
            nxt.upper_probe      = state_i.lower_probe;
            nxt.lower_probe      = shape_floor(down_clamp, integer_mode_i);
            nxt.upper_value      = lower_value_new;
            nxt.pending_is_upper = 1'b0;
            res.probe_bandwidth  = nxt.lower_probe;
          end
        end else begin
          nxt.phase    = gss_pkg::PH_IDLE;
          res.done_res = 1'b1;
        end
      end
    end

    res.best_bandwidth = (nxt.upper_value < nxt.lower_value) ? nxt.upper_probe
                                                             : nxt.lower_probe;
    res.iterations     = nxt.iteration_count;
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the golden-section search sequencer.
// Drives start and criterion items, predicts every result item in a scoreboard
// class and compares field by field; needs gss_pkg and the three channel interfaces.
module testbench;

  localparam int unsigned ITEMS_TARGET = 1950;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned REPORT_CAP   = 10;
  localparam logic [gss_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam gss_pkg::bw_t FRAC_MASK =
    gss_pkg::BW_W'((1 << gss_pkg::FRACTION_BITS_DEF) - 1);
  localparam logic [gss_pkg::BW_W:0] HALF_ONE =
    (gss_pkg::BW_W+1)'(1 << (gss_pkg::FRACTION_BITS_DEF - 1));
  localparam gss_pkg::bw_t EPS_Q =
    gss_pkg::BW_W'(((1 << gss_pkg::FRACTION_BITS_DEF) + 5000) / 10000);
  localparam gss_pkg::crit_t CRIT_MIN = {1'b1, {(gss_pkg::CRIT_W-1){1'b0}}};

  class gss_search_tracker;
    gss_pkg::bw_t         reg_lower, reg_upper;
    logic                 reg_int_mode;
    gss_pkg::bw_t         low_end, high_end, step_len, upper_probe, lower_probe;
    gss_pkg::crit_t       upper_value, lower_value;
    int unsigned          iter_count;
    gss_pkg::phase_e      phase;
    logic                 pending_upper;
    gss_pkg::gss_result_t steps_due[$];
    int unsigned          items_noted, results_seen, mismatches;

    function new();
      reg_lower = '0;
      reg_upper = '0;
      reg_int_mode = 1'b0;
      low_end = '0;
      high_end = '0;
      step_len = '0;
      upper_probe = '0;
      lower_probe = '0;
      upper_value = gss_pkg::CRIT_MAX;
      lower_value = gss_pkg::CRIT_MAX;
      iter_count = 0;
      phase = gss_pkg::PH_IDLE;
      pending_upper = 1'b1;
      items_noted = 0;
      results_seen = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [gss_pkg::CFG_IDX_W-1:0] idx, gss_pkg::bw_t data);
      case (idx)
        gss_pkg::CFG_SEARCH_LOWER: reg_lower = data;
        gss_pkg::CFG_SEARCH_UPPER: reg_upper = data;
        gss_pkg::CFG_INTEGER_MODE: reg_int_mode = data[0];
        default: ;
      endcase
    endfunction

    // floor(x * 0.618...) with the Q0.32 ratio
    function gss_pkg::bw_t golden_scale(gss_pkg::bw_t x);
      logic [gss_pkg::BW_W+gss_pkg::GOLD_W-1:0] prod;
      prod = {{gss_pkg::GOLD_W{1'b0}}, x} * {{gss_pkg::BW_W{1'b0}}, gss_pkg::GOLDEN_Q32};
      return prod[gss_pkg::BW_W+gss_pkg::GOLD_W-1:gss_pkg::GOLD_W];
    endfunction

    function gss_pkg::bw_t to_whole(gss_pkg::bw_t x, bit round_half_up);
      logic [gss_pkg::BW_W:0] t;
      t = {1'b0, x};
      if (!reg_int_mode) return x;
      if (round_half_up) begin
        t = t + HALF_ONE;
        if (t > {1'b0, gss_pkg::BW_MAX}) t = {1'b0, gss_pkg::BW_MAX};
      end
      return t[gss_pkg::BW_W-1:0] & ~FRAC_MASK;
    endfunction

    function bit search_continues();
      logic signed [gss_pkg::CRIT_W+1:0] diff;
      diff = {{2{lower_value[gss_pkg::CRIT_W-1]}}, lower_value} -
             {{2{upper_value[gss_pkg::CRIT_W-1]}}, upper_value};
      if (diff < 0) diff = -diff;
      return step_len > EPS_Q && diff > EPS_Q && iter_count < gss_pkg::MAX_ITERATIONS_DEF;
    endfunction

    // keep the side with the lower criterion and return the new probe
    function gss_pkg::bw_t narrow_pair();
      logic [gss_pkg::BW_W:0] sum;
      step_len = golden_scale(step_len);
      if (upper_value < lower_value) begin
        low_end = lower_probe;
        lower_probe = upper_probe;
        sum = {1'b0, low_end} + {1'b0, step_len};
        if (sum > {1'b0, gss_pkg::BW_MAX}) sum = {1'b0, gss_pkg::BW_MAX};
        upper_probe = to_whole(sum[gss_pkg::BW_W-1:0], 1'b1);
        lower_value = upper_value;
        pending_upper = 1'b1;
        return upper_probe;
      end
      high_end = upper_probe;
      upper_probe = lower_probe;
      lower_probe = to_whole(high_end > step_len ? high_end - step_len : '0, 1'b0);
      upper_value = lower_value;
      pending_upper = 1'b0;
      return lower_probe;
    endfunction

    function gss_pkg::gss_result_t note_item(gss_pkg::gss_item_t it);
      gss_pkg::gss_result_t r;
      gss_pkg::crit_t       v;
      gss_pkg::bw_t         lo, hi;
      r = '0;
      if (it.func == gss_pkg::FUNC_START) begin
        lo = reg_lower;
        hi = reg_upper;
        if (lo > hi) begin
          lo = reg_upper;
          hi = reg_lower;
        end
        low_end = lo;
        high_end = hi;
        step_len = golden_scale(hi - lo);
        upper_probe = to_whole(lo + step_len, 1'b0);
        lower_probe = to_whole(hi - step_len, 1'b1);
        upper_value = gss_pkg::CRIT_MAX;
        lower_value = gss_pkg::CRIT_MAX;
        iter_count = 0;
        pending_upper = 1'b1;
        phase = gss_pkg::PH_FIRST;
        r.probe_valid = 1'b1;
        r.probe_bandwidth = upper_probe;
      end else if (phase != gss_pkg::PH_IDLE) begin
        v = it.criterion_failed ? gss_pkg::CRIT_MAX : it.criterion;
        if (!it.criterion_failed) begin
          r.record_valid = 1'b1;
          r.record_criterion = it.criterion;
          r.record_bandwidth = pending_upper ? upper_probe : lower_probe;
        end
        if (pending_upper) upper_value = v;
        else lower_value = v;
        if (phase == gss_pkg::PH_FIRST) begin
          pending_upper = 1'b0;
          phase = gss_pkg::PH_SECOND;
          r.probe_valid = 1'b1;
          r.probe_bandwidth = lower_probe;
        end else begin
          if (phase == gss_pkg::PH_ITER) iter_count++;
          if (search_continues()) begin
            r.probe_bandwidth = narrow_pair();
            r.probe_valid = 1'b1;
            phase = gss_pkg::PH_ITER;
          end else begin
            r.done_res = 1'b1;
            phase = gss_pkg::PH_IDLE;
          end
        end
      end
      r.best_bandwidth = (upper_value < lower_value) ? upper_probe : lower_probe;
      r.iterations = iter_count[gss_pkg::ITER_W-1:0];
      steps_due = {steps_due, r};
      items_noted++;
      return r;
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("result %0d: %s expected %h, got %h", results_seen, what, want, got);
      end
    endfunction

    function void check_result(gss_pkg::gss_result_t got);
      gss_pkg::gss_result_t want;
      results_seen++;
      if (steps_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("result %0d arrived with no item outstanding", results_seen);
        return;
      end
      want = steps_due.pop_front();
      compare_field("probe_valid", want.probe_valid, got.probe_valid);
      compare_field("probe_bandwidth", want.probe_bandwidth, got.probe_bandwidth);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("best_bandwidth", want.best_bandwidth, got.best_bandwidth);
      compare_field("record_valid", want.record_valid, got.record_valid);
      compare_field("record_bandwidth", want.record_bandwidth, got.record_bandwidth);
      compare_field("record_criterion", want.record_criterion, got.record_criterion);
      compare_field("iterations", want.iterations, got.iterations);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   sender_quiet;

  gss_item_if   item_if();
  gss_result_if res_if();
  gss_cfg_if    cfg_if();

  gss_search_tracker sb = new();

  golden_section_search_sequencer u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic gss_pkg::bw_t rand_bw();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[gss_pkg::BW_W-1:0];
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic offer_item(input logic func, input gss_pkg::crit_t crit,
                            input logic failed, output gss_pkg::gss_result_t want);
    gss_pkg::gss_item_t it;
    int unsigned        gap;
    it.func = func;
    it.criterion = crit;
    it.criterion_failed = failed;
    item_if.valid <= 1'b1;
    item_if.func <= func;
    item_if.criterion <= crit;
    item_if.criterion_failed <= failed;
    do @(posedge clk); while (!item_if.ready);
    want = sb.note_item(it);
    gap = sender_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and hold until every result item is back
  task automatic settle_block();
    item_if.valid <= 1'b0;
    while (sb.steps_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gss_pkg::CFG_IDX_W-1:0] idx,
                           input gss_pkg::bw_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input gss_pkg::bw_t lower, input gss_pkg::bw_t upper,
                           input gss_pkg::bw_t mode_word, input logic [2:0] which);
    if (which[0]) write_reg(gss_pkg::CFG_SEARCH_LOWER, lower);
    if (which[1]) write_reg(gss_pkg::CFG_SEARCH_UPPER, upper);
    if (which[2]) write_reg(gss_pkg::CFG_INTEGER_MODE, mode_word);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : result_sink
    gss_pkg::gss_result_t got;
    int unsigned          stall_left, burst_left;
    bit                   quiet, long_hold_done;
    logic                 rdy;
    stall_left = 0;
    burst_left = 0;
    quiet = 1'b0;
    long_hold_done = 1'b0;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        got.probe_valid = res_if.probe_valid;
        got.probe_bandwidth = res_if.probe_bandwidth;
        got.done_res = res_if.done_res;
        got.best_bandwidth = res_if.best_bandwidth;
        got.record_valid = res_if.record_valid;
        got.record_bandwidth = res_if.record_bandwidth;
        got.record_criterion = res_if.record_criterion;
        got.iterations = res_if.iterations;
        sb.check_result(got);
      end
      if (burst_left == 0) begin
        quiet = ($urandom_range(0, 2) == 0);
        burst_left = $urandom_range(50, 300);
      end else begin
        burst_left--;
      end
      // hold off long enough for the block to back up into its input
      if (!long_hold_done && sb.items_noted >= 600) begin
        long_hold_done = 1'b1;
        stall_left = 400;
      end
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (!quiet) stall_left = pick_gap();
      end
      res_if.ready <= rdy;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    gss_pkg::gss_result_t want;
    gss_pkg::bw_t         span, lo_cfg, probe_now, target, distance;
    gss_pkg::crit_t       offset;
    logic [95:0]          scaled;
    int unsigned          shift_n, roll, first_random;
    int                   off_i;
    bit                   running, need_cfg;
    logic [2:0]           which;

    item_if.valid = 1'b0;
    item_if.func = gss_pkg::FUNC_START;
    item_if.criterion = '0;
    item_if.criterion_failed = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = gss_pkg::CFG_SEARCH_LOWER;
    cfg_if.data = '0;
    sender_quiet = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // criterion while idle does nothing
    offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::CRIT_MAX, 1'b0, want);
    settle_block();
    configure('0, gss_pkg::BW_MAX, '0, 3'b111);
    offer_item(gss_pkg::FUNC_START, '0, 1'b0, want);
    offer_item(gss_pkg::FUNC_DELIVER, CRIT_MIN, 1'b0, want);
    offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::CRIT_MAX, 1'b0, want);
    offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(rand_bw()), 1'b1, want);
    offer_item(gss_pkg::FUNC_DELIVER, '0, 1'b0, want);
    offer_item(gss_pkg::FUNC_DELIVER, '1, 1'b0, want);
    // restart in the middle of the iterations
    offer_item(gss_pkg::FUNC_START, gss_pkg::crit_t'(rand_bw()), 1'b1, want);
    offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(rand_bw()), 1'b0, want);
    settle_block();
    // swapped ends, integer mode; two failed values tie and end the search
    write_reg(CFG_SPARE, rand_bw());
    configure(gss_pkg::BW_MAX, '0, gss_pkg::BW_MAX, 3'b111);
    offer_item(gss_pkg::FUNC_START, '0, 1'b0, want);
    offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(rand_bw()), 1'b1, want);
    offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(rand_bw()), 1'b1, want);
    offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(rand_bw()), 1'b0, want);
    settle_block();
    // empty interval at the top: rounding saturates, step is zero
    configure(gss_pkg::BW_MAX, gss_pkg::BW_MAX, '0, 3'b011);
    offer_item(gss_pkg::FUNC_START, '0, 1'b0, want);
    offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(5), 1'b0, want);
    offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(100), 1'b0, want);

    first_random = sb.items_noted;
    need_cfg = 1'b1;
    while (sb.items_noted - first_random < ITEMS_TARGET) begin
      if (need_cfg || $urandom_range(0, 2) == 0) begin
        settle_block();
        roll = $urandom_range(0, 9);
        span = rand_bw();
        if (roll < 6) span = span >> $urandom_range(24, 44);
        else if (roll < 9) span = span >> $urandom_range(8, 23);
        case ($urandom_range(0, 3))
          0: lo_cfg = '0;
          1: lo_cfg = gss_pkg::BW_MAX - span;
          default: begin
            lo_cfg = rand_bw();
            if (lo_cfg > gss_pkg::BW_MAX - span) lo_cfg = gss_pkg::BW_MAX - span;
          end
        endcase
        which = need_cfg ? 3'b111 : 3'($urandom_range(1, 7));
        if ($urandom_range(0, 3) == 0) configure(lo_cfg + span, lo_cfg, rand_bw(), which);
        else configure(lo_cfg, lo_cfg + span, rand_bw(), which);
        need_cfg = 1'b0;
      end
      sender_quiet = ($urandom_range(0, 3) == 0);

      // unimodal criterion around a point inside the current interval
      lo_cfg = (sb.reg_lower < sb.reg_upper) ? sb.reg_lower : sb.reg_upper;
      span = ((sb.reg_lower < sb.reg_upper) ? sb.reg_upper : sb.reg_lower) - lo_cfg;
      scaled = {48'd0, rand_bw()} * {48'd0, span};
      target = lo_cfg + scaled[95:48];
      shift_n = $urandom_range(1, 4);
      off_i = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      offset = gss_pkg::crit_t'(off_i);

      offer_item(gss_pkg::FUNC_START, gss_pkg::crit_t'(rand_bw()),
                 1'($urandom_range(0, 1)), want);
      probe_now = want.probe_bandwidth;
      running = 1'b1;
      while (running && sb.items_noted - first_random < ITEMS_TARGET) begin
        if ($urandom_range(0, 79) == 0) break;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(rand_bw()), 1'b1, want);
        end else if (roll < 8) begin
          offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(rand_bw()), 1'b0, want);
        end else begin
          distance = (probe_now > target) ? probe_now - target : target - probe_now;
          offer_item(gss_pkg::FUNC_DELIVER,
                     gss_pkg::crit_t'(distance >> shift_n) + offset, 1'b0, want);
        end
        if (want.done_res) running = 1'b0;
        else if (want.probe_valid) probe_now = want.probe_bandwidth;
      end
      if (!running && $urandom_range(0, 3) == 0)
        offer_item(gss_pkg::FUNC_DELIVER, gss_pkg::crit_t'(rand_bw()),
                   1'($urandom_range(0, 1)), want);
    end

    settle_block();
    if (sb.mismatches == 0 && sb.steps_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
